>>> rtl/fade_ordered_dither_pattern_macros.svh
// ----------------------------------------------------------------------------
// Fade dither assertion macros
// Shared wrappers for the concurrent checks on the fade engine ports.
// ----------------------------------------------------------------------------
`ifndef FADE_ORDERED_DITHER_PATTERN_MACROS_SVH
`define FADE_ORDERED_DITHER_PATTERN_MACROS_SVH

// Check on every rising edge outside reset.
`define FODP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every rising edge, reset included.
`define FODP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/fodp_pkg.sv
// ----------------------------------------------------------------------------
// Fade dither package
// Codes, widths, the 8x8 Bayer table and the mask builder of the fade engine.
// ----------------------------------------------------------------------------
package fodp_pkg;

  localparam int TIME_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int FIELD_W    = 16;   // delta_time and fade_length
  localparam int PROG_W     = 9;
  localparam int THR_W      = 7;
  localparam int MASK_W     = 64;
  localparam int QUOT_W     = 9;
  localparam int DIV_CNT_W  = 4;

  localparam logic [PROG_W-1:0]    PROG_FULL   = 9'd256;
  localparam logic [DIV_CNT_W-1:0] PROG_STEPS  = 4'd9;
  localparam logic [DIV_CNT_W-1:0] THR_STEPS   = 4'd7;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_IN   = 2'd1,
    DIR_OUT  = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    DRAW_NONE   = 2'd0,
    DRAW_SOLID  = 2'd1,
    DRAW_DITHER = 2'd2
  } draw_kind_e;

  typedef enum logic [1:0] {
    CFG_WHITE     = 2'd0,
    CFG_DIRECTION = 2'd1,
    CFG_LENGTH    = 2'd2
  } cfg_idx_e;

  // Classification of one result, decided in the front end.
  typedef struct packed {
    draw_kind_e kind;
    logic       white;
    logic       active;
  } cls_t;

  localparam logic [5:0] BAYER [64] = '{
    6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
    6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
    6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
    6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
    6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
    6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
    6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
    6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
  };

  // Row 0 lands in the top byte, column 0 in bit 7 of each byte.
  function automatic logic [MASK_W-1:0] build_mask(input logic [THR_W-1:0] thr);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int i = 0; i < MASK_W; i++) begin
      m[MASK_W-1-i] = ({1'b0, BAYER[i]} < thr);
    end
    return m;
  endfunction

endpackage

>>> rtl/fodp_queue.sv
// ----------------------------------------------------------------------------
// Fade dither job queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module fodp_queue #(
  parameter int W     = 8,
  parameter int DEPTH = fodp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/fodp_div.sv
// ----------------------------------------------------------------------------
// Fade dither divider
// Restoring divider, one quotient bit per cycle, shared by progress and
// threshold.
// ----------------------------------------------------------------------------
module fodp_div #(
  parameter int TIME_BITS = fodp_pkg::TIME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [TIME_BITS:0]             rem_i,
  input  logic [fodp_pkg::QUOT_W-1:0]    low_i,
  input  logic [TIME_BITS:0]             div_i,
  input  logic [fodp_pkg::DIV_CNT_W-1:0] steps_i,
  output logic                           done_o,
  output logic [fodp_pkg::QUOT_W-1:0]    quot_o
);

  localparam int RW = TIME_BITS + 1;

  logic [RW-1:0]                    rem_q, rem_d;
  logic [RW-1:0]                    div_q;
  logic [fodp_pkg::QUOT_W-1:0]      low_q, low_d;
  logic [fodp_pkg::QUOT_W-1:0]      quot_q, quot_d;
  logic [fodp_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic                             busy_q, done_q;
  logic [RW:0]                      rem_sh, rem_sub;
  logic                             ge;

  // Bring down the next numerator bit, subtract when it fits.
  always_comb begin
    rem_sh  = {rem_q, low_q[fodp_pkg::QUOT_W-1]};
    ge      = (rem_sh >= {1'b0, div_q});
    rem_sub = rem_sh - {1'b0, div_q};
    rem_d   = ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
    low_d   = {low_q[fodp_pkg::QUOT_W-2:0], 1'b0};
    quot_d  = {quot_q[fodp_pkg::QUOT_W-2:0], ge};
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      div_q  <= '0;
      low_q  <= '0;
      quot_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= rem_i;
        div_q  <= div_i;
        low_q  <= low_i;
        quot_q <= '0;
        cnt_q  <= steps_i;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q  <= rem_d;
        low_q  <= low_d;
        quot_q <= quot_d;
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == fodp_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/fodp_front.sv
// ----------------------------------------------------------------------------
// Fade dither front end
// Holds the registers and fade state, applies each item and classifies the
// result for the back end.
// ----------------------------------------------------------------------------
module fodp_front #(
  parameter int TIME_BITS = fodp_pkg::TIME_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [fodp_pkg::FIELD_W-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   mode_i,
  input  logic [fodp_pkg::FIELD_W-1:0] delta_time_i,
  input  logic                         full_i,
  output logic                         push_o,
  output fodp_pkg::cls_t               cls_o,
  output logic [TIME_BITS-1:0]         len_o,
  output logic [TIME_BITS-1:0]         elapsed_o,
  output logic [TIME_BITS-1:0]         num_o
);

  localparam int LW = (TIME_BITS > fodp_pkg::FIELD_W) ? TIME_BITS : fodp_pkg::FIELD_W;
  localparam int SW = LW + 1;
  localparam logic [SW-1:0] TMAX = {{(SW - TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};

  logic                         fade_white_q;
  logic [1:0]                   fade_dir_q;
  logic [fodp_pkg::FIELD_W-1:0] fade_len_q;

  logic [TIME_BITS-1:0] elapsed_q, elapsed_d;
  logic                 running_q, running_d;
  fodp_pkg::dir_e       dir_q, dir_d;
  logic                 white_q, white_d;
  logic [TIME_BITS-1:0] len_q, len_d;

  logic                 accept;
  logic [SW-1:0]        cfg_len_w, cfg_len_sat;
  logic [TIME_BITS-1:0] start_len;
  logic [SW-1:0]        sum_w, sum_sat;
  logic [TIME_BITS-1:0] e_c, num;
  fodp_pkg::cls_t       cls;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full_i;
  assign accept      = in_valid_i && in_ready_o;

  // Saturate the latched length into the time range, never below one.
  always_comb begin
    cfg_len_w   = SW'(fade_len_q);
    cfg_len_sat = (cfg_len_w > TMAX) ? TMAX : cfg_len_w;
    start_len   = cfg_len_sat[TIME_BITS-1:0];
    if (start_len == '0) begin
      start_len = TIME_BITS'(1);
    end
    sum_w   = SW'(elapsed_q) + SW'(delta_time_i);
    sum_sat = (sum_w > TMAX) ? TMAX : sum_w;
  end

  always_comb begin
    elapsed_d = elapsed_q;
    running_d = running_q;
    dir_d     = dir_q;
    white_d   = white_q;
    len_d     = len_q;
    if (accept) begin
      unique case (mode_i)
        fodp_pkg::MODE_TICK: begin
          if (running_q) begin
            if (sum_sat >= SW'(len_q)) begin
              elapsed_d = len_q;
              running_d = 1'b0;
            end else begin
              elapsed_d = sum_sat[TIME_BITS-1:0];
            end
          end
        end
        fodp_pkg::MODE_START: begin
          if (fade_dir_q == fodp_pkg::DIR_IN || fade_dir_q == fodp_pkg::DIR_OUT) begin
            white_d   = fade_white_q;
            dir_d     = fodp_pkg::dir_e'(fade_dir_q);
            len_d     = start_len;
            elapsed_d = '0;
            running_d = 1'b1;
          end else begin
            dir_d     = fodp_pkg::DIR_NONE;
            len_d     = '0;
            elapsed_d = '0;
            running_d = 1'b0;
          end
        end
        fodp_pkg::MODE_STOP: begin
          dir_d     = fodp_pkg::DIR_NONE;
          len_d     = '0;
          elapsed_d = '0;
          running_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Classify from the state after the item.
  always_comb begin
    e_c        = (elapsed_d > len_d) ? len_d : elapsed_d;
    num        = (dir_d == fodp_pkg::DIR_IN) ? (len_d - e_c) : e_c;
    cls.kind   = fodp_pkg::DRAW_NONE;
    cls.white  = 1'b0;
    cls.active = running_d;
    if (dir_d == fodp_pkg::DIR_IN || dir_d == fodp_pkg::DIR_OUT) begin
      if (len_d == '0) begin
        cls.kind = fodp_pkg::DRAW_SOLID;
      end else if (num == '0) begin
        cls.kind = fodp_pkg::DRAW_NONE;
      end else if (num >= len_d) begin
        cls.kind = fodp_pkg::DRAW_SOLID;
      end else begin
        cls.kind = fodp_pkg::DRAW_DITHER;
      end
      if (cls.kind != fodp_pkg::DRAW_NONE) begin
        cls.white = white_d;
      end
    end
  end

  assign push_o    = accept;
  assign cls_o     = cls;
  assign len_o     = len_d;
  assign elapsed_o = elapsed_d;
  assign num_o     = num;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_white_q <= 1'b0;
      fade_dir_q   <= fodp_pkg::DIR_NONE;
      fade_len_q   <= fodp_pkg::FIELD_W'(1);
      elapsed_q    <= '0;
      running_q    <= 1'b0;
      dir_q        <= fodp_pkg::DIR_NONE;
      white_q      <= 1'b0;
      len_q        <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          fodp_pkg::CFG_WHITE:     fade_white_q <= cfg_data_i[0];
          fodp_pkg::CFG_DIRECTION: fade_dir_q   <= cfg_data_i[1:0];
          fodp_pkg::CFG_LENGTH:    fade_len_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
      elapsed_q <= elapsed_d;
      running_q <= running_d;
      dir_q     <= dir_d;
      white_q   <= white_d;
      len_q     <= len_d;
    end
  end

endmodule

>>> rtl/fodp_back.sv
// ----------------------------------------------------------------------------
// Fade dither back end
// Pops classified jobs, runs progress and threshold through the shared
// divider, builds the mask and holds the result register.
// ----------------------------------------------------------------------------
module fodp_back #(
  parameter int TIME_BITS = fodp_pkg::TIME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  output logic                        pop_o,
  input  fodp_pkg::cls_t              cls_i,
  input  logic [TIME_BITS-1:0]        len_i,
  input  logic [TIME_BITS-1:0]        elapsed_i,
  input  logic [TIME_BITS-1:0]        num_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  draw_kind_o,
  output logic                        draw_white_o,
  output logic [fodp_pkg::MASK_W-1:0] mask_rows_o,
  output logic                        is_active_o,
  output logic [fodp_pkg::PROG_W-1:0] progress_o
);

  localparam int RW = TIME_BITS + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROG,
    ST_THR
  } state_e;

  state_e                         state_q;
  fodp_pkg::cls_t                 cls_q;
  logic [TIME_BITS-1:0]           len_q;
  logic [TIME_BITS-1:0]           num_q;

  logic                           out_valid_q;
  logic [1:0]                     kind_q;
  logic                           white_q;
  logic [fodp_pkg::MASK_W-1:0]    mask_q;
  logic                           active_q;
  logic [fodp_pkg::PROG_W-1:0]    prog_q;

  logic                           div_start;
  logic [RW-1:0]                  div_rem;
  logic [fodp_pkg::QUOT_W-1:0]    div_low;
  logic [RW-1:0]                  div_den;
  logic [fodp_pkg::DIV_CNT_W-1:0] div_steps;
  logic                           div_done;
  logic [fodp_pkg::QUOT_W-1:0]    div_quot;

  assign pop_o = (state_q == ST_IDLE) && !empty_i && !out_valid_q;

  // Progress: 256*elapsed / length. Threshold: (128*num + length) / (2*length).
  always_comb begin
    div_start = 1'b0;
    div_rem   = RW'(elapsed_i >> 1);
    div_low   = {elapsed_i[0], 8'b0};
    div_den   = RW'(len_i);
    div_steps = fodp_pkg::PROG_STEPS;
    if (pop_o && len_i != '0) begin
      div_start = 1'b1;
    end else if (state_q == ST_PROG && div_done && cls_q.kind == fodp_pkg::DRAW_DITHER) begin
      div_start = 1'b1;
      div_rem   = RW'(num_q) + RW'(len_q >> 7);
      div_low   = {len_q[6:0], 2'b0};
      div_den   = {len_q, 1'b0};
      div_steps = fodp_pkg::THR_STEPS;
    end
  end

  fodp_div #(
    .TIME_BITS(TIME_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .rem_i  (div_rem),
    .low_i  (div_low),
    .div_i  (div_den),
    .steps_i(div_steps),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cls_q       <= '0;
      len_q       <= '0;
      num_q       <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= fodp_pkg::DRAW_NONE;
      white_q     <= 1'b0;
      mask_q      <= '0;
      active_q    <= 1'b0;
      prog_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            cls_q    <= cls_i;
            len_q    <= len_i;
            num_q    <= num_i;
            kind_q   <= cls_i.kind;
            white_q  <= cls_i.white;
            active_q <= cls_i.active;
            mask_q   <= '0;
            if (len_i == '0) begin
              // Stopped: nothing to divide.
              prog_q      <= fodp_pkg::PROG_FULL;
              out_valid_q <= 1'b1;
            end else begin
              state_q <= ST_PROG;
            end
          end
        end
        ST_PROG: begin
          if (div_done) begin
            prog_q <= div_quot;
            if (cls_q.kind == fodp_pkg::DRAW_DITHER) begin
              state_q <= ST_THR;
            end else begin
              out_valid_q <= 1'b1;
              state_q     <= ST_IDLE;
            end
          end
        end
        ST_THR: begin
          if (div_done) begin
            mask_q      <= fodp_pkg::build_mask(div_quot[fodp_pkg::THR_W-1:0]);
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign draw_kind_o  = kind_q;
  assign draw_white_o = white_q;
  assign mask_rows_o  = mask_q;
  assign is_active_o  = active_q;
  assign progress_o   = prog_q;

endmodule

>>> rtl/fade_ordered_dither_pattern.sv
// ----------------------------------------------------------------------------
// Fade engine with ordered-dither mask
// Screen fade timing with an 8x8 Bayer mask result per start, stop or tick.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake                  Payload
//  cfg      in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//  in       in   in_valid_i / in_ready_o    mode_i, delta_time_i
//  out      out  out_valid_o / out_ready_i  draw_kind_o, draw_white_o,
//                                           mask_rows_o, is_active_o, progress_o
//
// The front end applies an item in the cycle it is accepted; the queue holds
// up to QUEUE_DEPTH jobs. The back end runs one job at a time through a shared
// bit-serial divider: 9 progress steps for a plain result, and 7 threshold
// steps more for a dither mask; a stopped result skips the divider.
// Reset is asynchronous and clears all control state; no clearing pass.
// A stalled output holds the back end; the front takes items until the queue fills.
// ----------------------------------------------------------------------------
module fade_ordered_dither_pattern #(
  parameter int TIME_BITS   = fodp_pkg::TIME_BITS_DEF,
  parameter int QUEUE_DEPTH = fodp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [fodp_pkg::FIELD_W-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   mode_i,
  input  logic [fodp_pkg::FIELD_W-1:0] delta_time_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   draw_kind_o,
  output logic                         draw_white_o,
  output logic [fodp_pkg::MASK_W-1:0]  mask_rows_o,
  output logic                         is_active_o,
  output logic [fodp_pkg::PROG_W-1:0]  progress_o
);

  localparam int CLS_W = $bits(fodp_pkg::cls_t);
  localparam int JOB_W = CLS_W + 3 * TIME_BITS;

  logic                 push, full, pop, empty;
  fodp_pkg::cls_t       f_cls, b_cls;
  logic [TIME_BITS-1:0] f_len, f_elapsed, f_num;
  logic [TIME_BITS-1:0] b_len, b_elapsed, b_num;
  logic [JOB_W-1:0]     q_in, q_out;

  fodp_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .delta_time_i(delta_time_i),
    .full_i      (full),
    .push_o      (push),
    .cls_o       (f_cls),
    .len_o       (f_len),
    .elapsed_o   (f_elapsed),
    .num_o       (f_num)
  );

  assign q_in = {f_cls, f_len, f_elapsed, f_num};

  fodp_queue #(
    .W    (JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_in),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (q_out)
  );

  assign {b_cls, b_len, b_elapsed, b_num} = q_out;

  fodp_back #(
    .TIME_BITS(TIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .cls_i       (b_cls),
    .len_i       (b_len),
    .elapsed_i   (b_elapsed),
    .num_i       (b_num),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .draw_kind_o (draw_kind_o),
    .draw_white_o(draw_white_o),
    .mask_rows_o (mask_rows_o),
    .is_active_o (is_active_o),
    .progress_o  (progress_o)
  );

endmodule

>>> rtl/fodp_checker.sv
// ----------------------------------------------------------------------------
// Fade dither port checker
// Concurrent checks on the result channel of the fade engine.
// ----------------------------------------------------------------------------
`include "fade_ordered_dither_pattern_macros.svh"

module fodp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [1:0]                  draw_kind_o,
  input logic                        draw_white_o,
  input logic [fodp_pkg::MASK_W-1:0] mask_rows_o,
  input logic                        is_active_o,
  input logic [fodp_pkg::PROG_W-1:0] progress_o
);

  `FODP_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "result valid during reset")

  `FODP_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(mask_rows_o) && $stable(progress_o) && $stable(draw_kind_o), "stalled result changed")

  `FODP_ASSERT(a_mask_only_dither, out_valid_o && draw_kind_o != fodp_pkg::DRAW_DITHER |-> mask_rows_o == '0, "mask set without dither")

  `FODP_ASSERT(a_none_black, out_valid_o && draw_kind_o == fodp_pkg::DRAW_NONE |-> !draw_white_o, "white set with nothing drawn")

  `FODP_ASSERT(a_active_prog, out_valid_o && is_active_o |-> progress_o < fodp_pkg::PROG_FULL, "running fade reports full progress")

endmodule

bind fade_ordered_dither_pattern fodp_checker u_fodp_checker (.*);
